// ===== src/dtfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: shared package
// Default sizes and elaboration-time helpers used by the parser blocks.
// ----------------------------------------------------------------------------
package dtfx_pkg;

  // Default geometry of the fixed-point result.
  localparam int unsigned FRAC_BITS_DEF       = 16;
  localparam int unsigned INT_BITS_DEF        = 15;
  localparam int unsigned MAX_FRAC_DIGITS_DEF = 9;

  // Width of one character beat and of the result word.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;

  // Number of finished strings that can wait between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Bit positions of the result flags on the output user bus.
  localparam int unsigned USER_W       = 2;
  localparam int unsigned USER_BAD_BIT = 0;
  localparam int unsigned USER_OVF_BIT = 1;

  // Ten to the power n, for constant arguments only.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Bits that hold any decimal integer of up to n digits.
  function automatic int unsigned frac_val_w(input int unsigned n);
    return $clog2(pow10(n));
  endfunction

  // Bits that hold a digit count from zero to n.
  function automatic int unsigned digit_cnt_w(input int unsigned n);
    return $clog2(n + 1);
  endfunction

endpackage

// ===== src/dtfx_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: record queue
// Small register queue that carries finished parse records to the back end.
// ----------------------------------------------------------------------------
module dtfx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dtfx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  import dtfx_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/dtfx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: character parser
// Takes one character per beat, tracks sign, integer and fraction digits,
// and hands a finished record to the queue on the beat marked last.
// ----------------------------------------------------------------------------
module dtfx_front #(
  parameter int unsigned INT_BITS        = dtfx_pkg::INT_BITS_DEF,
  parameter int unsigned MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF,
  localparam int unsigned FvW  = dtfx_pkg::frac_val_w(MAX_FRAC_DIGITS),
  localparam int unsigned CntW = dtfx_pkg::digit_cnt_w(MAX_FRAC_DIGITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [dtfx_pkg::CHAR_W-1:0] s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  input  logic                        full_i,
  output logic                        push_o,
  output logic                        neg_o,
  output logic [INT_BITS-1:0]         int_o,
  output logic                        ovf_o,
  output logic [FvW-1:0]              fval_o,
  output logic [CntW-1:0]             fcnt_o,
  output logic                        serr_o
);
  import dtfx_pkg::*;

  // Parse phases.
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  logic [1:0]          phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [INT_BITS-1:0] int_q, int_d;
  logic                ovf_q, ovf_d;
  logic [FvW-1:0]      fval_q, fval_d;
  logic [CntW-1:0]     fcnt_q, fcnt_d;
  logic                serr_q, serr_d;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [INT_BITS+3:0]   int_acc;
  logic                  int_big;
  logic [FvW+3:0]        frac_acc;
  logic [1:0]            end_phase;
  logic                  end_err;
  logic                  accept;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept && s_axis_tlast_i;

  assign is_digit = (s_axis_tdata_i >= CH_ZERO) && (s_axis_tdata_i <= CH_NINE);
  assign digit    = 4'(s_axis_tdata_i - CH_ZERO);

  // Integer digit: times ten by shift and add, saturating past the limit.
  assign int_acc = ((INT_BITS + 4)'(int_q) << 3) + ((INT_BITS + 4)'(int_q) << 1)
                 + (INT_BITS + 4)'(digit);
  assign int_big = ovf_q || (|int_acc[INT_BITS+3:INT_BITS]);

  // Fraction digit: kept as an exact decimal integer.
  assign frac_acc = ((FvW + 4)'(fval_q) << 3) + ((FvW + 4)'(fval_q) << 1)
                  + (FvW + 4)'(digit);

  // A non-digit that closes the integer part.
  always_comb begin
    end_err = 1'b0;
    priority if (s_axis_tdata_i == CH_DOT) begin
      end_phase = PH_FRAC;
    end else if ((s_axis_tdata_i == CH_NUL) || (s_axis_tdata_i == CH_LF)) begin
      end_phase = PH_DONE;
    end else begin
      end_phase = PH_DONE;
      end_err   = 1'b1;
    end
  end

  // Next parse state for the current character.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    ovf_d   = ovf_q;
    fval_d  = fval_q;
    fcnt_d  = fcnt_q;
    serr_d  = serr_q;
    unique case (phase_q)
      PH_LEAD: begin
        priority if (s_axis_tdata_i == CH_SPACE) begin
          phase_d = PH_LEAD;
        end else if (s_axis_tdata_i == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end else if (s_axis_tdata_i == CH_PLUS) begin
          phase_d = PH_INT;
        end else if (is_digit) begin
          phase_d = PH_INT;
          ovf_d   = int_big;
          int_d   = int_big ? '1 : int_acc[INT_BITS-1:0];
        end else begin
          phase_d = end_phase;
          serr_d  = serr_q | end_err;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          ovf_d = int_big;
          int_d = int_big ? '1 : int_acc[INT_BITS-1:0];
        end else begin
          phase_d = end_phase;
          serr_d  = serr_q | end_err;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (fcnt_q < CntW'(MAX_FRAC_DIGITS)) begin
            fval_d = frac_acc[FvW-1:0];
            fcnt_d = fcnt_q + CntW'(1);
          end
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  // The record handed on is the state after the last character.
  assign neg_o  = neg_d;
  assign int_o  = int_d;
  assign ovf_o  = ovf_d;
  assign fval_o = fval_d;
  assign fcnt_o = fcnt_d;
  assign serr_o = serr_d;

  // Parse state, cleared after each finished string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      int_q   <= '0;
      ovf_q   <= 1'b0;
      fval_q  <= '0;
      fcnt_q  <= '0;
      serr_q  <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        phase_q <= PH_LEAD;
        neg_q   <= 1'b0;
        int_q   <= '0;
        ovf_q   <= 1'b0;
        fval_q  <= '0;
        fcnt_q  <= '0;
        serr_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        int_q   <= int_d;
        ovf_q   <= ovf_d;
        fval_q  <= fval_d;
        fcnt_q  <= fcnt_d;
        serr_q  <= serr_d;
      end
    end
  end

endmodule

// ===== src/dtfx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: fraction converter and result stage
// Divides the kept fraction digits by the matching power of ten one bit per
// cycle, then assembles the signed result in the output register.
// ----------------------------------------------------------------------------
module dtfx_back #(
  parameter int unsigned FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
  parameter int unsigned INT_BITS        = dtfx_pkg::INT_BITS_DEF,
  parameter int unsigned MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF,
  localparam int unsigned FvW  = dtfx_pkg::frac_val_w(MAX_FRAC_DIGITS),
  localparam int unsigned CntW = dtfx_pkg::digit_cnt_w(MAX_FRAC_DIGITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  logic                         neg_i,
  input  logic [INT_BITS-1:0]          int_i,
  input  logic                         ovf_i,
  input  logic [FvW-1:0]               fval_i,
  input  logic [CntW-1:0]              fcnt_i,
  input  logic                         serr_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [dtfx_pkg::VALUE_W-1:0] m_axis_tdata_o,
  output logic [dtfx_pkg::USER_W-1:0]  m_axis_tuser_o
);
  import dtfx_pkg::*;

  localparam int unsigned MagW  = INT_BITS + FRAC_BITS;
  localparam int unsigned WideW = (MagW > VALUE_W) ? MagW : VALUE_W;
  localparam int unsigned BitW  = $clog2(FRAC_BITS);
  localparam int unsigned TabN  = 2 ** CntW;

  // Converter states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [BitW-1:0]      bit_q, bit_d;
  logic                 neg_q, ovf_q, serr_q;
  logic [INT_BITS-1:0]  int_q;
  logic [FvW-1:0]       rem_q, rem_d;
  logic [FvW-1:0]       div_q;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic                 tvalid_q;
  logic [VALUE_W-1:0]   value_q;
  logic [USER_W-1:0]    user_q;

  logic [FvW-1:0]       pow_tab [TabN];
  logic [FvW:0]         rem_sh;
  logic                 take_bit;
  logic                 load_rec;
  logic                 load_out;
  logic [WideW-1:0]     mag_wide;
  logic [VALUE_W-1:0]   mag32;
  logic [VALUE_W-1:0]   value_d;
  logic [USER_W-1:0]    user_d;

  // Power-of-ten divisor table, one entry per digit count.
  for (genvar g = 0; g < TabN; g++) begin : g_pow
    if (g <= MAX_FRAC_DIGITS) begin : g_used
      assign pow_tab[g] = FvW'(pow10(g));
    end else begin : g_spare
      assign pow_tab[g] = FvW'(pow10(MAX_FRAC_DIGITS));
    end
  end

  assign load_rec = (state_q == ST_IDLE) && !empty_i;
  assign pop_o    = load_rec;
  assign load_out = (state_q == ST_OUT) && (!tvalid_q || m_axis_tready_i);

  // One restoring division step.
  assign rem_sh   = {rem_q, 1'b0};
  assign take_bit = (rem_sh >= {1'b0, div_q});

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    frac_d  = frac_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load_rec) begin
          state_d = ST_DIV;
          bit_d   = BitW'(FRAC_BITS - 1);
          rem_d   = fval_i;
          frac_d  = '0;
        end
      end
      ST_DIV: begin
        rem_d  = take_bit ? FvW'(rem_sh - {1'b0, div_q}) : rem_sh[FvW-1:0];
        frac_d = {frac_q[FRAC_BITS-2:0], take_bit};
        if (bit_q == '0) begin
          state_d = ST_OUT;
        end else begin
          bit_d = bit_q - BitW'(1);
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result assembly: saturate, negate, and force zero on a syntax error.
  assign mag_wide = ovf_q ? WideW'({MagW{1'b1}}) : WideW'({int_q, frac_q});
  assign mag32    = mag_wide[VALUE_W-1:0];
  always_comb begin
    if (serr_q) begin
      value_d = '0;
    end else if (neg_q) begin
      value_d = '0 - mag32;
    end else begin
      value_d = mag32;
    end
    user_d               = '0;
    user_d[USER_BAD_BIT] = serr_q;
    user_d[USER_OVF_BIT] = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    frac_q <= frac_d;
    if (load_rec) begin
      neg_q  <= neg_i;
      int_q  <= int_i;
      ovf_q  <= ovf_i;
      serr_q <= serr_i;
      div_q  <= pow_tab[fcnt_i];
    end
    if (load_out) begin
      value_q <= value_d;
      user_q  <= user_d;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = value_q;
  assign m_axis_tuser_o  = user_q;

endmodule

// ===== src/decimal_text_to_fixed_point_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: top level
// Converts a stream of ASCII decimal text into signed fixed-point numbers.
// ----------------------------------------------------------------------------
// Characters are taken one per clock, one string per run of beats closed by
// tlast, and each string yields one result beat carrying the value in signed
// Q(INT_BITS).(FRAC_BITS) with bad-syntax and overflow flags. The parser takes
// a character every cycle as long as the record queue (two strings deep) has
// room. The fraction converter divides the kept fraction digits by a power of
// ten one quotient bit per cycle and takes the next string only once the last
// result is in the output register, so when strings arrive faster than that,
// the division loop sets the pace.
module decimal_text_to_fixed_point_top #(
  parameter int unsigned FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
  parameter int unsigned INT_BITS        = dtfx_pkg::INT_BITS_DEF,
  parameter int unsigned MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [dtfx_pkg::CHAR_W-1:0]  s_axis_tdata_i,  // [7:0] character
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [dtfx_pkg::VALUE_W-1:0] m_axis_tdata_o,  // [31:0] value
  output logic [dtfx_pkg::USER_W-1:0]  m_axis_tuser_o   // [0] bad_syntax, [1] overflow
);
  import dtfx_pkg::*;

  localparam int unsigned FvW  = frac_val_w(MAX_FRAC_DIGITS);
  localparam int unsigned CntW = digit_cnt_w(MAX_FRAC_DIGITS);
  localparam int unsigned RecW = 1 + INT_BITS + 1 + FvW + CntW + 1;

  logic                push, pop, full, empty;
  logic [RecW-1:0]     rec_in, rec_out;

  logic                f_neg, f_ovf, f_serr;
  logic [INT_BITS-1:0] f_int;
  logic [FvW-1:0]      f_fval;
  logic [CntW-1:0]     f_fcnt;

  logic                b_neg, b_ovf, b_serr;
  logic [INT_BITS-1:0] b_int;
  logic [FvW-1:0]      b_fval;
  logic [CntW-1:0]     b_fcnt;

  // Character parser.
  dtfx_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .full_i          (full),
    .push_o          (push),
    .neg_o           (f_neg),
    .int_o           (f_int),
    .ovf_o           (f_ovf),
    .fval_o          (f_fval),
    .fcnt_o          (f_fcnt),
    .serr_o          (f_serr)
  );

  // Finished records travel packed through the queue.
  assign rec_in = {f_serr, f_fcnt, f_fval, f_ovf, f_int, f_neg};
  assign {b_serr, b_fcnt, b_fval, b_ovf, b_int, b_neg} = rec_out;

  dtfx_fifo #(
    .WIDTH (RecW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .pop_i   (pop),
    .data_o  (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Fraction converter and result register.
  dtfx_back #(
    .FRAC_BITS       (FRAC_BITS),
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_o           (pop),
    .neg_i           (b_neg),
    .int_i           (b_int),
    .ovf_i           (b_ovf),
    .fval_i          (b_fval),
    .fcnt_i          (b_fcnt),
    .serr_i          (b_serr),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== src/dtfx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: port checker
// Watches the top-level ports for result payload and stream behavior.
// ----------------------------------------------------------------------------
module dtfx_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tlast_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [dtfx_pkg::VALUE_W-1:0] m_axis_tdata_o,
  input logic [dtfx_pkg::USER_W-1:0]  m_axis_tuser_o
);
  import dtfx_pkg::*;

  // Strings whose last beat went in and whose result has not been taken.
  logic [2:0] pending_q, pending_d;
  logic       in_done, out_done;

  assign in_done  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_done = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_done && !out_done) begin
      pending_d = pending_q + 3'd1;
    end else if (out_done && !in_done) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  // A syntax error always reports a zero value.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[USER_BAD_BIT] |-> m_axis_tdata_o == '0)
    else $error("nonzero value with bad syntax flag");

  // No result without a finished string behind it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != 3'd0)
    else $error("result beat without a finished input string");

  // Queue, converter and output register bound the strings in flight.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more strings in flight than the design can hold");

endmodule

bind decimal_text_to_fixed_point_top dtfx_checker u_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: testbench
// Streams ASCII number strings into the converter with random gaps and
// output stalls. Each accepted character goes through a parser model kept
// here, and every result beat is checked against the oldest expected number.
// ----------------------------------------------------------------------------

// Parser phases of the model kept by the testbench.
typedef enum logic [1:0] {
  SCAN_LEAD,
  SCAN_INT,
  SCAN_FRAC,
  SCAN_DONE
} scan_phase_e;

// One expected result beat.
typedef struct packed {
  logic [dtfx_pkg::VALUE_W-1:0] value;
  logic                         bad_syntax;
  logic                         overflow;
} fixed_result_t;

typedef byte unsigned char_q_t[$];

// Characters with a meaning to the parser.
localparam byte unsigned CH_NUL   = 8'h00;
localparam byte unsigned CH_NL    = 8'h0A;
localparam byte unsigned CH_SPACE = 8'h20;
localparam byte unsigned CH_PLUS  = 8'h2B;
localparam byte unsigned CH_MINUS = 8'h2D;
localparam byte unsigned CH_DOT   = 8'h2E;
localparam byte unsigned CH_ZERO  = 8'h30;
localparam byte unsigned CH_NINE  = 8'h39;

// Parses the characters as the block should and checks the result beats.
class number_scoreboard;
  localparam int unsigned FRAC_W      = dtfx_pkg::FRAC_BITS_DEF;
  localparam int unsigned INT_W       = dtfx_pkg::INT_BITS_DEF;
  localparam int unsigned MAX_DIGITS  = dtfx_pkg::MAX_FRAC_DIGITS_DEF;
  localparam int unsigned MAX_REPORTS = 10;

  scan_phase_e     phase;
  bit              negative;
  int unsigned     int_part;
  bit              int_overflow;
  longint unsigned frac_digits;
  int unsigned     frac_count;
  bit              syntax_error;

  fixed_result_t   expected_numbers[$];
  int unsigned     failures;

  function new();
    clear_parse();
    failures = 0;
  endfunction

  function void clear_parse();
    phase        = SCAN_LEAD;
    negative     = 1'b0;
    int_part     = 0;
    int_overflow = 1'b0;
    frac_digits  = 0;
    frac_count   = 0;
    syntax_error = 1'b0;
  endfunction

  // Integer digits saturate at the largest integer part.
  function void add_int_digit(byte unsigned c);
    int unsigned limit;
    int unsigned next;
    limit = (1 << INT_W) - 1;
    next  = int_part * 10 + (c - CH_ZERO);
    if (int_overflow || next > limit) begin
      int_overflow = 1'b1;
      int_part     = limit;
    end else begin
      int_part = next;
    end
  endfunction

  // A non-digit closes the integer part: a dot opens the fraction, NUL or
  // newline finishes cleanly, and anything else is a syntax error.
  function void end_integer(byte unsigned c);
    if (c == CH_DOT) begin
      phase = SCAN_FRAC;
    end else if (c == CH_NUL || c == CH_NL) begin
      phase = SCAN_DONE;
    end else begin
      syntax_error = 1'b1;
      phase        = SCAN_DONE;
    end
  endfunction

  // Takes one accepted character; the last one of a string queues a result.
  function void parse_char(byte unsigned c, bit last);
    bit              is_digit;
    longint unsigned pow;
    longint unsigned frac;
    logic [63:0]     mag;
    fixed_result_t   res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (phase)
      SCAN_LEAD: begin
        if (c == CH_SPACE) begin
          // Leading spaces are skipped.
        end else if (c == CH_MINUS) begin
          negative = 1'b1;
          phase    = SCAN_INT;
        end else if (c == CH_PLUS) begin
          phase = SCAN_INT;
        end else if (is_digit) begin
          phase = SCAN_INT;
          add_int_digit(c);
        end else begin
          end_integer(c);
        end
      end
      SCAN_INT: begin
        if (is_digit) add_int_digit(c);
        else end_integer(c);
      end
      SCAN_FRAC: begin
        if (is_digit) begin
          // Digits past the kept count are dropped.
          if (frac_count < MAX_DIGITS) begin
            frac_digits = frac_digits * 10 + (c - CH_ZERO);
            frac_count++;
          end
        end else begin
          phase = SCAN_DONE;
        end
      end
      default: ;
    endcase
    if (!last) return;

    // Fraction bits are the kept digits scaled by 2^FRAC_W over 10^count,
    // truncated.
    pow = 1;
    repeat (frac_count) pow = pow * 10;
    frac = (frac_digits << FRAC_W) / pow;
    if (int_overflow) mag = (64'd1 << (INT_W + FRAC_W)) - 64'd1;
    else mag = (64'(int_part) << FRAC_W) | 64'(frac);
    if (negative) mag = 64'd0 - mag;
    if (syntax_error) mag = 64'd0;
    res.value      = mag[dtfx_pkg::VALUE_W-1:0];
    res.bad_syntax = syntax_error;
    res.overflow   = int_overflow;
    expected_numbers.push_back(res);
    clear_parse();
  endfunction

  // Compares one result beat with the oldest expected number.
  function void check_result(logic [dtfx_pkg::VALUE_W-1:0] value,
                             logic [dtfx_pkg::USER_W-1:0] user);
    fixed_result_t want;
    if (expected_numbers.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("ERROR: result beat with none expected: value=%h user=%b", value, user);
      return;
    end
    want = expected_numbers.pop_front();
    if (value !== want.value || user[dtfx_pkg::USER_BAD_BIT] !== want.bad_syntax ||
        user[dtfx_pkg::USER_OVF_BIT] !== want.overflow) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("ERROR: expected value=%h bad=%b ovf=%b, got value=%h bad=%b ovf=%b",
                 want.value, want.bad_syntax, want.overflow, value,
                 user[dtfx_pkg::USER_BAD_BIT], user[dtfx_pkg::USER_OVF_BIT]);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned FRAC_W      = dtfx_pkg::FRAC_BITS_DEF;
  localparam int unsigned CHAR_TARGET = 1750;
  localparam int unsigned CALM_AFTER  = 1500;
  localparam int unsigned TAIL_CYCLES = 4 * (FRAC_W + 3);

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [dtfx_pkg::CHAR_W-1:0]  s_axis_tdata_i  = '0;
  logic                         s_axis_tlast_i  = 1'b0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [dtfx_pkg::VALUE_W-1:0] m_axis_tdata_o;
  logic [dtfx_pkg::USER_W-1:0]  m_axis_tuser_o;

  number_scoreboard scoreboard = new();
  int unsigned      chars_sent = 0;
  bit               calm       = 1'b0;
  int unsigned      ready_hold = 0;

  decimal_text_to_fixed_point_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // Output stalls come in random bursts until the calm tail.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold      <= ready_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      ready_hold      <= $urandom_range(0, 9);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Every result beat taken is checked.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      scoreboard.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Watchdog for a stuck handshake.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Drives one character beat and waits until it is taken.
  task automatic send_char(input byte unsigned c, input bit last);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    scoreboard.parse_char(c, last);
    chars_sent++;
    calm = (chars_sent >= CALM_AFTER);
    @(negedge clk_i);
    // Input gaps, also in random bursts.
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  // Sends a whole string with tlast on its final character.
  task automatic send_text(input char_q_t text);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  function automatic char_q_t text_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Builds one random string: mostly well-formed numbers with random
  // content, some pure noise and some with one character broken.
  function automatic char_q_t make_number_text();
    char_q_t     q;
    int unsigned kind;
    string       near_limit;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
    case ($urandom_range(0, 2))
      1: q.push_back(CH_MINUS);
      2: q.push_back(CH_PLUS);
      default: ;
    endcase
    // Integer digits, now and then right around the saturation point.
    if ($urandom_range(0, 7) == 0) begin
      near_limit = $sformatf("%0d", 32760 + $urandom_range(0, 15));
      for (int i = 0; i < near_limit.len(); i++) q.push_back(near_limit[i]);
    end else begin
      repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
    // Fraction, sometimes with more digits than are kept.
    if ($urandom_range(0, 2) != 0) begin
      q.push_back(CH_DOT);
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9))
        q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
    case ($urandom_range(0, 3))
      1: q.push_back(CH_NUL);
      2: q.push_back(CH_NL);
      3: q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    // Random trailing characters; the parser ignores them once the number is finished.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    if (q.size() == 0) q.push_back(8'($urandom_range(0, 255)));
    if (kind == 1) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    return q;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed strings: top and bottom character codes, empty number, space
    // after a sign, negative saturation, a fraction without integer digits
    // and with dropped digits, text after a newline, and a bad character.
    send_char(8'hFF, 1'b1);
    send_char(CH_NUL, 1'b1);
    send_text(text_chars("- 1"));
    send_text(text_chars("-99999"));
    send_text(text_chars(".12345678901"));
    send_text(text_chars("7\nZ"));
    send_text(text_chars("+1a"));

    while (chars_sent < CHAR_TARGET) send_text(make_number_text());
    s_axis_tvalid_i <= 1'b0;

    while (scoreboard.expected_numbers.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (scoreboard.failures == 0 && scoreboard.expected_numbers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
